/* hw/rtl/luhn_pkg.sv */
// Shared types and constants for the card number Luhn and issuer check.
`timescale 1ns / 1ps
package luhn_pkg;

  typedef enum logic [4:0] {
    ISS_NONE     = 5'd0,
    ISS_CHARGE   = 5'd1,
    ISS_AU_BANK  = 5'd2,
    ISS_CN_UNION = 5'd3,
    ISS_DC_CARTE = 5'd4,
    ISS_DC_ER    = 5'd5,
    ISS_DC_WORLD = 5'd6,
    ISS_DC       = 5'd7,
    ISS_US_NET   = 5'd8,
    ISS_IPAY     = 5'd9,
    ISS_ISTP     = 5'd10,
    ISS_JP       = 5'd11,
    ISS_IE       = 5'd12,
    ISS_DEBIT    = 5'd13,
    ISS_DK       = 5'd14,
    ISS_MC       = 5'd15,
    ISS_UK_A     = 5'd16,
    ISS_UK_B     = 5'd17,
    ISS_V        = 5'd18,
    ISS_VE       = 5'd19,
    ISS_AIR      = 5'd20
  } issuer_e;

  localparam int unsigned MinBytes = 12;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiSpace = 8'h20;

  localparam int unsigned NumVePfx = 7;
  localparam logic [31:0] VePrefixes [NumVePfx] = '{
    "4026", "4175", "4405", "4508", "4844", "4913", "4917"
  };

endpackage

/* hw/rtl/luhn_if.sv */
// Channel interfaces for card number bytes and check results.
`timescale 1ns / 1ps
interface luhn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface luhn_res_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [4:0] issuer;
  logic [3:0] check_digit;
  logic       check_mismatch;

  modport source (output valid, output accepted, output issuer, output check_digit,
                  output check_mismatch, input ready);
  modport sink   (input valid, input accepted, input issuer, input check_digit,
                  input check_mismatch, output ready);
endinterface

/* hw/rtl/card_number_luhn_issuer_check.sv */
// Top level of the streamed card number Luhn check with issuer classification.
`timescale 1ns / 1ps
// The block takes one ASCII byte per transfer and can accept a byte in every cycle. A byte
// first lands in an input register; from there it updates the running Luhn sums, counts and
// prefix, while a final byte loads the result register instead, so each result passes the
// input register and then the result register. The result register parts the two sides:
// bytes keep flowing while a result waits, and only a final byte stalls if the previous result
// is still held. Exactly one result is given per final byte; a rejected number gives all zeros.
module card_number_luhn_issuer_check import luhn_pkg::*; #(
  parameter int unsigned MAX_BYTES = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  luhn_in_if.sink    in_i,
  luhn_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BYTES);
  localparam logic [CntW-1:0] CntMin = CntW'(MinBytes);

  function automatic logic in_rng(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic [3:0] add_mod10(logic [3:0] a, logic [3:0] b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

  function automatic issuer_e debit_or_none(logic [5:0] k);
    return (k >= 6'd12 && k <= 6'd19) ? ISS_DEBIT : ISS_NONE;
  endfunction

  function automatic issuer_e classify(logic [31:0] pfx, logic [5:0] k);
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic       ve;
    issuer_e    r;
    p0 = pfx[31:24];
    p1 = pfx[23:16];
    p2 = pfx[15:8];
    ve = 1'b0;
    r  = ISS_NONE;
    for (int i = 0; i < NumVePfx; i++) begin
      if (pfx == VePrefixes[i]) begin
        ve = 1'b1;
      end
    end
    unique case (p0)
      "1": r = (k == 6'd15) ? ISS_AIR : ISS_NONE;
      "2": begin
        priority if (p1 == "0" || p1 == "1") begin
          r = (k == 6'd15) ? ISS_DC_ER : ISS_NONE;
        end else if (in_rng(p1, "2", "7")) begin
          r = (k == 6'd16) ? ISS_MC : ISS_NONE;
        end else begin
          r = ISS_NONE;
        end
      end
      "3": begin
        priority if (p1 == "4" || p1 == "7") begin
          r = (k == 6'd15) ? ISS_CHARGE : ISS_NONE;
        end else if (p1 == "5") begin
          r = (k == 6'd16 && in_rng(p2, "2", "8")) ? ISS_JP : ISS_NONE;
        end else if (p1 == "0" && k == 6'd14 && in_rng(p2, "0", "5")) begin
          r = ISS_DC_CARTE;
        end else if (p1 == "0" || p1 == "6" || p1 == "8" || p1 == "9") begin
          r = (k == 6'd14) ? ISS_DC_WORLD : ISS_NONE;
        end else begin
          r = ISS_NONE;
        end
      end
      "4": begin
        priority if (k == 6'd16 && ve) begin
          r = ISS_VE;
        end else if (k == 6'd13 || k == 6'd16) begin
          r = ISS_V;
        end else begin
          r = ISS_NONE;
        end
      end
      "5": begin
        priority if (in_rng(p1, "0", "5")) begin
          r = (k == 6'd16) ? ISS_MC : ISS_NONE;
        end else if (in_rng(p1, "6", "9")) begin
          r = debit_or_none(k);
        end else begin
          r = ISS_NONE;
        end
      end
      "6": begin
        priority if (p1 == "2") begin
          r = (k >= 6'd16 && k <= 6'd19) ? ISS_CN_UNION : ISS_NONE;
        end else if (p1 == "0" || p1 == "4" || p1 == "5") begin
          r = (k == 6'd16) ? ISS_US_NET : ISS_NONE;
        end else if (p1 == "3") begin
          priority if (p2 == "6" && k >= 6'd16 && k <= 6'd19) begin
            r = ISS_IPAY;
          end else if (in_rng(p2, "7", "9") && k == 6'd16) begin
            r = ISS_ISTP;
          end else begin
            r = debit_or_none(k);
          end
        end else if (p1 == "1" || in_rng(p1, "6", "9")) begin
          r = debit_or_none(k);
        end else begin
          r = ISS_NONE;
        end
      end
      default: r = ISS_NONE;
    endcase
    return r;
  endfunction

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_go;

  // Running state.
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [4:0]      digit_cnt_q, digit_cnt_d;
  logic [3:0]      sum_even_q, sum_even_d;
  logic [3:0]      sum_odd_q, sum_odd_d;
  logic [7:0]      prefix_q [4];
  logic [7:0]      prefix_d [4];
  logic            bad_q, bad_d;

  // Result register.
  logic       res_valid_q, res_valid_d;
  logic       res_acc_q, res_acc_d;
  logic [4:0] res_iss_q, res_iss_d;
  logic [3:0] res_chk_q, res_chk_d;
  logic       res_mis_q, res_mis_d;

  logic            res_free;
  logic            is_digit;
  logic [3:0]      dig;
  logic [4:0]      dbl;
  logic [3:0]      dig2;
  logic [CntW-1:0] byte_cnt_inc;
  logic [5:0]      k;
  logic [3:0]      sum_sel;
  logic [3:0]      chk;
  logic            len_ok;
  issuer_e         iss;

  assign res_free   = !res_valid_q || res_o.ready;
  assign s1_go      = s1_valid_q && (!s1_last_q || res_free);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign s1_valid_d = (in_i.valid && in_i.ready) || (s1_valid_q && !s1_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.char_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    is_digit     = (s1_byte_q[7:4] == AsciiZero[7:4]) && (s1_byte_q[3:0] < 4'd10);
    dig          = s1_byte_q[3:0];
    dbl          = {dig, 1'b0};
    dig2         = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
    byte_cnt_inc = (byte_cnt_q < CntSat) ? byte_cnt_q + 1'b1 : byte_cnt_q;
    k            = {1'b0, digit_cnt_q} + 6'd1;
    sum_sel      = k[0] ? sum_odd_q : sum_even_q;
    chk          = (sum_sel == 4'd0) ? 4'd0 : 4'(5'd10 - {1'b0, sum_sel});
    len_ok       = (byte_cnt_inc >= CntMin) && (byte_cnt_inc <= CntMax);
    iss          = (!bad_q && len_ok) ? classify({prefix_q[0], prefix_q[1], prefix_q[2],
                                                  prefix_q[3]}, k) : ISS_NONE;

    byte_cnt_d  = byte_cnt_q;
    digit_cnt_d = digit_cnt_q;
    sum_even_d  = sum_even_q;
    sum_odd_d   = sum_odd_q;
    prefix_d    = prefix_q;
    bad_d       = bad_q;
    res_acc_d   = res_acc_q;
    res_iss_d   = res_iss_q;
    res_chk_d   = res_chk_q;
    res_mis_d   = res_mis_q;
    res_valid_d = res_valid_q && !res_o.ready;

    if (s1_go) begin
      if (s1_last_q) begin
        byte_cnt_d  = '0;
        digit_cnt_d = '0;
        sum_even_d  = '0;
        sum_odd_d   = '0;
        prefix_d    = '{default: '0};
        bad_d       = 1'b0;
        res_valid_d = 1'b1;
        res_acc_d   = (iss != ISS_NONE);
        res_iss_d   = iss;
        res_chk_d   = (iss != ISS_NONE) ? chk : 4'd0;
        res_mis_d   = (iss != ISS_NONE) && (s1_byte_q != {AsciiZero[7:4], chk});
      end else begin
        byte_cnt_d = byte_cnt_inc;
        if (byte_cnt_q < CntW'(4)) begin
          prefix_d[byte_cnt_q[1:0]] = s1_byte_q;
        end
        if (s1_byte_q != AsciiSpace) begin
          if (!is_digit) begin
            bad_d = 1'b1;
          end else begin
            if (!digit_cnt_q[0]) begin
              sum_even_d = add_mod10(sum_even_q, dig2);
              sum_odd_d  = add_mod10(sum_odd_q, dig);
            end else begin
              sum_even_d = add_mod10(sum_even_q, dig);
              sum_odd_d  = add_mod10(sum_odd_q, dig2);
            end
            if (digit_cnt_q != 5'd31) begin
              digit_cnt_d = digit_cnt_q + 5'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      digit_cnt_q <= '0;
      sum_even_q  <= '0;
      sum_odd_q   <= '0;
      prefix_q    <= '{default: '0};
      bad_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      byte_cnt_q  <= byte_cnt_d;
      digit_cnt_q <= digit_cnt_d;
      sum_even_q  <= sum_even_d;
      sum_odd_q   <= sum_odd_d;
      prefix_q    <= prefix_d;
      bad_q       <= bad_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_acc_q <= res_acc_d;
    res_iss_q <= res_iss_d;
    res_chk_q <= res_chk_d;
    res_mis_q <= res_mis_d;
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.accepted       = res_acc_q;
  assign res_o.issuer         = res_iss_q;
  assign res_o.check_digit    = res_chk_q;
  assign res_o.check_mismatch = res_mis_q;

endmodule

/* hw/rtl/luhn_chk.sv */
// Port-level checks on the card number check block, bound to its top level.
`timescale 1ns / 1ps
module luhn_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_accepted_i,
  input logic [4:0] res_issuer_i,
  input logic [3:0] res_check_digit_i,
  input logic       res_check_mismatch_i
);

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_accepted_i |->
      res_issuer_i == 5'd0 && res_check_digit_i == 4'd0 && !res_check_mismatch_i)
    else $error("rejected result carries non-zero fields");

  a_accept_issuer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_accepted_i |-> res_issuer_i != 5'd0 && res_issuer_i <= 5'd20)
    else $error("accepted result without a valid issuer code");

  a_check_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_check_digit_i <= 4'd9)
    else $error("check digit out of range");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_accepted_i) &&
      $stable(res_issuer_i) && $stable(res_check_digit_i) && $stable(res_check_mismatch_i))
    else $error("stalled result changed");

endmodule

bind card_number_luhn_issuer_check luhn_chk u_luhn_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .res_valid_i          (res_o.valid),
  .res_ready_i          (res_o.ready),
  .res_accepted_i       (res_o.accepted),
  .res_issuer_i         (res_o.issuer),
  .res_check_digit_i    (res_o.check_digit),
  .res_check_mismatch_i (res_o.check_mismatch)
);
